// ===== hdl/ppc_pkg.sv =====
// Package for the product perfect-power checker.
// Item kinds, status codes and shared types. No dependencies.
package ppc_pkg;
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_ADD_DONE  = 2'd0,
    ST_ADD_FULL  = 2'd1,
    ST_IS_POW    = 2'd2,
    ST_NOT_POW   = 2'd3
  } status_t;

  localparam int EXP_BITS   = 32;
  localparam int POWER_BITS = 16;
endpackage

// ===== hdl/ppc_if.sv =====
// Valid/ready channel interfaces for the perfect-power checker.
// Depends on ppc_pkg.
interface ppc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [31:0]                   value;
  logic [ppc_pkg::POWER_BITS-1:0] power;
  modport source (output valid, kind, value, power, input ready);
  modport sink   (input valid, kind, value, power, output ready);
endinterface

interface ppc_out_if;
  logic                valid;
  logic                ready;
  ppc_pkg::status_t    status;
  modport source (output valid, status, input ready);
  modport sink   (input valid, status, output ready);
endinterface

// ===== hdl/product_perfect_power_checker.sv =====
// Product perfect-power checker: factorizes added values by trial division
// into a prime/exponent table held in RAM and tests exact k-th powers.
//
// Usage:
//   in  channel (valid/ready): kind, value, power. kind 0 adds value to the
//       running product, kind 1 asks whether the product is a power-th power.
//   out channel (valid/ready): status, one beat per input beat.
// One item at a time; in_ready is high only while the engine is idle.
// With DW = max(VALUE_BITS, 32) as the divider width, an add tries trial
// divisors up to the square root of the remaining value and, per prime
// found, scans the table entries for a match before it adds or updates one.
// A query divides each stored exponent by power until one is not divisible.
// Values 0 and 1 and power 0 take the shortest path, from S_IDLE straight
// to S_OUT; the result beat and the next input beat can then go together.
// Reset clears the entry count; the RAMs need no clearing since only
// entries below the count are read. One result register parts the channels:
// while out_ready is low the result beat holds, the engine takes and works
// one more item, then waits with that result until the held beat leaves.
module product_perfect_power_checker
  import ppc_pkg::*;
#(
  parameter int TABLE_DEPTH = 256,
  parameter int VALUE_BITS  = 32
) (
  input  logic clk,
  input  logic rst_n,
  ppc_in_if.sink    in_ch,
  ppc_out_if.source out_ch
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int DW = (VALUE_BITS > EXP_BITS) ? VALUE_BITS : EXP_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_DIVW, S_LOOK, S_LOOKW, S_CMP, S_QRD, S_QWAIT, S_QDIV,
    S_QDIVW, S_OUT
  } state_t;

  state_t             state_r;
  logic [CW-1:0]      count_r;
  logic [VALUE_BITS-1:0] n_r, d_r, p_r;
  logic [EXP_BITS-1:0]   cnt_r;
  logic               last_r, full_r;
  logic [CW-1:0]      walk_r;
  logic [POWER_BITS-1:0] k_r;
  status_t            status_r;
  status_t            ostatus_r;
  logic               ovalid_r;
  logic [VALUE_BITS-1:0] in_val;

  // RAM ports
  logic                  kwe, ewe;
  logic [AW-1:0]         waddr, raddr;
  logic [VALUE_BITS-1:0] kwdata, krdata;
  logic [EXP_BITS-1:0]   ewdata, erdata;

  ppc_ram #(.WIDTH(VALUE_BITS), .DEPTH(TABLE_DEPTH)) u_keys (
    .clk, .we(kwe), .waddr, .wdata(kwdata), .raddr, .rdata(krdata));
  ppc_ram #(.WIDTH(EXP_BITS), .DEPTH(TABLE_DEPTH)) u_exps (
    .clk, .we(ewe), .waddr, .wdata(ewdata), .raddr, .rdata(erdata));

  // divider
  logic          dv_start, dv_done;
  logic [DW-1:0] dv_num, dv_den, dv_quo, dv_rem;
  ppc_divu #(.W(DW)) u_div (
    .clk, .rst_n, .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quo(dv_quo), .rem(dv_rem));

  logic [EXP_BITS:0] esum;
  assign esum = {1'b0, erdata} + {1'b0, cnt_r};

  assign in_val = VALUE_BITS'(in_ch.value);
  assign raddr = walk_r[AW-1:0];
  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = ovalid_r;
  assign out_ch.status = ostatus_r;

  always_comb begin
    kwe = 1'b0; ewe = 1'b0; waddr = walk_r[AW-1:0];
    kwdata = p_r; ewdata = cnt_r;
    dv_start = 1'b0;
    dv_num = DW'(n_r); dv_den = DW'(d_r);
    if (state_r == S_DIV) dv_start = 1'b1;
    if (state_r == S_QDIV) begin
      dv_start = 1'b1;
      dv_num = DW'(erdata);
      dv_den = DW'(k_r);
    end
    if (state_r == S_CMP) begin
      if (walk_r < count_r && krdata == p_r) begin
        ewe = 1'b1; waddr = walk_r[AW-1:0];
        ewdata = esum[EXP_BITS] ? '1 : esum[EXP_BITS-1:0];
      end else if (walk_r >= count_r && count_r < CW'(TABLE_DEPTH)) begin
        kwe = 1'b1; ewe = 1'b1; waddr = count_r[AW-1:0];
      end
    end
  end

  // d*d kept alongside d: (d+1)^2 = d^2 + 2d + 1
  logic [2*VALUE_BITS-1:0] dsq_r;
  logic [2*VALUE_BITS-1:0] dsq_nxt;
  assign dsq_nxt = dsq_r + (2*VALUE_BITS)'({d_r, 1'b1});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && (!ovalid_r || out_ch.ready)) begin
        ovalid_r  <= 1'b1;
        ostatus_r <= status_r;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          full_r <= 1'b0;
          walk_r <= '0;
          k_r    <= in_ch.power;
          n_r    <= in_val;
          d_r    <= VALUE_BITS'(2);
          dsq_r  <= (2*VALUE_BITS)'(4);
          cnt_r  <= '0;
          if (in_ch.kind == KIND_QUERY) begin
            if (in_ch.power == '0) begin
              status_r <= (count_r == '0) ? ST_IS_POW : ST_NOT_POW;
              state_r  <= S_OUT;
            end else state_r <= S_QRD;
          end else if (in_val < VALUE_BITS'(2)) begin
            status_r <= ST_ADD_DONE;
            state_r  <= S_OUT;
          end else state_r <= S_DIV;
        end
        S_DIV: begin
          if (dsq_r > {{VALUE_BITS{1'b0}}, n_r}) begin
            if (cnt_r != '0) begin
              p_r <= d_r; last_r <= 1'b0; walk_r <= '0; state_r <= S_LOOK;
            end else if (n_r > VALUE_BITS'(1)) begin
              p_r <= n_r; cnt_r <= EXP_BITS'(1); last_r <= 1'b1;
              walk_r <= '0; state_r <= S_LOOK;
            end else begin
              status_r <= full_r ? ST_ADD_FULL : ST_ADD_DONE;
              state_r  <= S_OUT;
            end
          end else state_r <= S_DIVW;
        end
        S_DIVW: if (dv_done) begin
          if (dv_rem == '0) begin
            n_r <= dv_quo[VALUE_BITS-1:0];
            cnt_r <= cnt_r + 1'b1;
            state_r <= S_DIV;
          end else if (cnt_r != '0) begin
            p_r <= d_r; last_r <= 1'b0; walk_r <= '0; state_r <= S_LOOK;
          end else begin
            d_r <= d_r + 1'b1; dsq_r <= dsq_nxt; state_r <= S_DIV;
          end
        end
        S_LOOK: state_r <= S_LOOKW;
        S_LOOKW: state_r <= S_CMP;
        S_CMP: begin
          if (walk_r < count_r && krdata != p_r) begin
            walk_r <= walk_r + 1'b1; state_r <= S_LOOK;
          end else begin
            if (walk_r >= count_r) begin
              if (count_r < CW'(TABLE_DEPTH)) count_r <= count_r + 1'b1;
              else full_r <= 1'b1;
            end
            cnt_r <= '0;
            if (last_r) begin
              status_r <= (full_r || (walk_r >= count_r &&
                          count_r >= CW'(TABLE_DEPTH))) ? ST_ADD_FULL : ST_ADD_DONE;
              state_r <= S_OUT;
            end else begin
              d_r <= d_r + 1'b1; dsq_r <= dsq_nxt; state_r <= S_DIV;
            end
          end
        end
        S_QRD: begin
          if (walk_r >= count_r) begin
            status_r <= ST_IS_POW; state_r <= S_OUT;
          end else state_r <= S_QWAIT;
        end
        S_QWAIT: state_r <= S_QDIV;
        S_QDIV: state_r <= S_QDIVW;
        S_QDIVW: if (dv_done) begin
          if (dv_rem != '0) begin
            status_r <= ST_NOT_POW; state_r <= S_OUT;
          end else begin
            walk_r <= walk_r + 1'b1; state_r <= S_QRD;
          end
        end
        S_OUT: if (!ovalid_r || out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/ppc_ram.sv =====
// Generic single-port-write, single-read synchronous RAM.
// Registered read. No dependencies.
module ppc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/ppc_divu.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Computes quotient and remainder of num / den. No dependencies.
module ppc_divu #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0]  q_r, r_r, d_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [W:0]    trial;

  assign trial = {r_r, q_r[W-1]} - {1'b0, d_r};
  assign quo  = q_r;
  assign rem  = r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        q_r    <= num;
        r_r    <= '0;
        d_r    <= den;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        if (!trial[W]) begin
          r_r <= trial[W-1:0];
          q_r <= {q_r[W-2:0], 1'b1};
        end else begin
          r_r <= {r_r[W-2:0], q_r[W-1]};
          q_r <= {q_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Testbench for product_perfect_power_checker: adds and queries with an
// in-bench prime/exponent table model. Depends on ppc_pkg and the ppc_if file.
module tb;
  import ppc_pkg::*;

  localparam int DEPTH = 256;
  localparam int NPRIMES_MAX = 600;

  class power_scoreboard;
    longint unsigned keys[DEPTH];
    int unsigned     exps[DEPTH];
    int unsigned     used;
    status_t         pending_q[$];
    int              errors;

    function new();
      used = 0;
      errors = 0;
    endfunction

    function bit credit(longint unsigned p, int unsigned cnt);
      for (int i = 0; i < used; i++) begin
        if (keys[i] == p) begin
          exps[i] = (32'hFFFF_FFFF - exps[i] < cnt) ? 32'hFFFF_FFFF : exps[i] + cnt;
          return 1'b1;
        end
      end
      if (used >= DEPTH) return 1'b0;
      keys[used] = p;
      exps[used] = cnt;
      used++;
      return 1'b1;
    endfunction

    function status_t factor_in(longint unsigned n);
      longint unsigned d;
      int unsigned cnt;
      bit full;
      full = 1'b0;
      if (n < 2) return ST_ADD_DONE;
      for (d = 2; d <= n / d; d++) begin
        if (n % d == 0) begin
          cnt = 0;
          while (n % d == 0) begin
            n = n / d;
            cnt++;
          end
          if (!credit(d, cnt)) full = 1'b1;
        end
      end
      if (n > 1 && !credit(n, 1)) full = 1'b1;
      return full ? ST_ADD_FULL : ST_ADD_DONE;
    endfunction

    function status_t power_test(logic [15:0] k);
      if (k == 0) return (used == 0) ? ST_IS_POW : ST_NOT_POW;
      for (int i = 0; i < used; i++)
        if (exps[i] % k != 0) return ST_NOT_POW;
      return ST_IS_POW;
    endfunction

    function void note_input(logic kind, logic [31:0] value, logic [15:0] power);
      if (kind == KIND_ADD) pending_q.push_back(factor_in(longint'(value)));
      else pending_q.push_back(power_test(power));
    endfunction

    function void check_result(status_t got);
      status_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: status %s", got.name());
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("status mismatch: expected %s actual %s", want.name(), got.name());
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  ppc_in_if in_ch();
  ppc_out_if out_ch();

  product_perfect_power_checker u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  power_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int unsigned primes[$];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_ADD;
    in_ch.value = '0;
    in_ch.power = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready = 1'b0;
      hold_cycles--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk)
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.status);

  task automatic send_item(logic kind, logic [31:0] value, logic [15:0] power);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.kind = kind;
    in_ch.value = value;
    in_ch.power = power;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(kind, value, power);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  function automatic logic [31:0] smooth_value();
    longint unsigned v, p;
    int terms, top;
    v = 1;
    terms = $urandom_range(1, 6);
    for (int t = 0; t < terms; t++) begin
      top = ($urandom_range(3) == 0) ? primes.size() - 1 : 40;
      p = primes[$urandom_range(top)];
      for (int e = $urandom_range(1, 3); e > 0; e--)
        if (v * p <= 64'hFFFF_FFFF) v = v * p;
    end
    return v[31:0];
  endfunction

  function automatic logic [15:0] pick_power();
    case ($urandom_range(9))
      0: return 16'($urandom_range(65535));
      1: return 16'hFFFF;
      default: return 16'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic random_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 25) send_item(KIND_QUERY, $urandom, pick_power());
      else if (r < 30) send_item(KIND_ADD, $urandom_range(1), 16'($urandom));
      else if (r < 50)
        send_item(KIND_ADD, primes[$urandom_range(primes.size() - 1)], 16'($urandom));
      else send_item(KIND_ADD, smooth_value(), 16'($urandom));
    end
  endtask

  initial begin
    bit comp;
    for (int n = 2; n < 4096 && primes.size() < NPRIMES_MAX; n++) begin
      comp = 1'b0;
      foreach (primes[j]) if (n % primes[j] == 0) comp = 1'b1;
      if (!comp) primes.push_back(n);
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_item(KIND_QUERY, 32'h0, 16'd0);
    send_item(KIND_QUERY, 32'h0, 16'd7);
    send_item(KIND_ADD, 32'd0, 16'hFFFF);
    send_item(KIND_ADD, 32'd1, 16'h0);
    send_item(KIND_QUERY, 32'hFFFF_FFFF, 16'd1);
    send_item(KIND_ADD, 32'h8000_0000, 16'h0);
    send_item(KIND_QUERY, 32'h0, 16'd31);
    send_item(KIND_QUERY, 32'h0, 16'd2);
    send_item(KIND_ADD, 32'hFFFF_FFFF, 16'h0);
    send_item(KIND_ADD, 32'd65521, 16'h0);
    send_item(KIND_ADD, 32'd1000003, 16'h0);
    send_item(KIND_ADD, 32'd36, 16'h0);
    send_item(KIND_QUERY, 32'h0, 16'd0);
    send_item(KIND_QUERY, 32'h0, 16'hFFFF);
    send_item(KIND_QUERY, 32'h0, 16'd1);
    send_item(KIND_ADD, 32'd2, 16'h0);
    send_item(KIND_QUERY, 32'h0, 16'd2);
    drain();

    hold_cycles = 400;
    random_phase(150);
    drain();
    send_idle_pct = 47;
    random_phase(140);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 47;
    random_phase(140);
    drain();
    send_idle_pct = 15;
    recv_stall_pct = 15;
    random_phase(150);
    drain();

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
